// ----- src/gsv_pkg.sv -----
`timescale 1ns / 1ps
package gsv_pkg;

  localparam int FRAC_BITS      = 12;
  localparam int ANG_SCALE_BITS = 30;
  localparam int GUARD_BITS     = 16;
  localparam int ATAN_LEN       = 24;
  localparam int SQRT_STEPS     = 16;
  localparam int CW             = 34;
  localparam int SQ_W           = 32;
  localparam int IN_W           = 16;
  localparam int ANG_W          = 16;
  localparam int DIST_W         = 16;
  localparam int SPEED_W        = 12;
  localparam int TURN_W         = 13;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int ANGLE_CFG_W    = 14;

  localparam logic signed [CW-1:0] PI_SCALED = 34'sd3373259426;

  localparam logic signed [CW-1:0] ATAN_TABLE [ATAN_LEN] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

  localparam int RATE_COARSE_I = ((1 << FRAC_BITS) * 2 + 5) / 10;
  localparam int RATE_SLOW_I   = ((1 << FRAC_BITS) + 5) / 10;
  localparam int RATE_FINE_I   = ((1 << FRAC_BITS) * 2 + 50) / 100;

  localparam logic [TURN_W-1:0] RATE_COARSE = TURN_W'(RATE_COARSE_I);
  localparam logic [TURN_W-1:0] RATE_SLOW   = TURN_W'(RATE_SLOW_I);
  localparam logic [TURN_W-1:0] RATE_FINE   = TURN_W'(RATE_FINE_I);

  localparam int ROUND_SHIFT = ANG_SCALE_BITS - FRAC_BITS;
  localparam logic signed [CW-1:0] ANG_ROUND = CW'(1) <<< (ROUND_SHIFT - 1);

  localparam int DIV10_SHIFT = 19;
  localparam int PROD_W      = 33;
  localparam logic [PROD_W-1:0] DIV10_MUL = PROD_W'(52429);
  localparam int QUOT_W      = PROD_W - DIV10_SHIFT;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COARSE_ANGLE    = 4'd0,
    CFG_SLOW_TURN_ANGLE = 4'd1,
    CFG_FINE_ANGLE      = 4'd2,
    CFG_ALIGNED_ANGLE   = 4'd3,
    CFG_ARRIVE_DISTANCE = 4'd4,
    CFG_FAR_DISTANCE    = 4'd5,
    CFG_FAST_SPEED      = 4'd6,
    CFG_CRUISE_SPEED    = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ANGLE_CFG_W-1:0] coarse_angle;
    logic [ANGLE_CFG_W-1:0] slow_turn_angle;
    logic [ANGLE_CFG_W-1:0] fine_angle;
    logic [ANGLE_CFG_W-1:0] aligned_angle;
    logic [DIST_W-1:0]      arrive_distance;
    logic [DIST_W-1:0]      far_distance;
    logic [SPEED_W-1:0]     fast_speed;
    logic [SPEED_W-1:0]     cruise_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    coarse_angle:    14'd819,
    slow_turn_angle: 14'd1229,
    fine_angle:      14'd123,
    aligned_angle:   14'd205,
    arrive_distance: 16'd205,
    far_distance:    16'd8192,
    fast_speed:      12'd1638,
    cruise_speed:    12'd1229
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    cordic_t cd;
    sqrt_t   sq;
  } core_t;

  function automatic cordic_t cordic_step(cordic_t c, int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    r  = c;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (!c.y[CW-1] && (c.y != '0)) begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ATAN_TABLE[i];
    end else if (c.y[CW-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ATAN_TABLE[i];
    end
    return r;
  endfunction

  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned k);
    sqrt_t r;
    logic [SQ_W-1:0] bit_v;
    logic [SQ_W:0]   trial;
    bit_v = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    trial = {1'b0, s.root} + {1'b0, bit_v};
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[SQ_W-1:0];
      r.root = (s.root >> 1) + bit_v;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

// ----- src/gsv_prep.sv -----
`timescale 1ns / 1ps
module gsv_prep (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [gsv_pkg::IN_W-1:0]     goal_forward_i,
  input  logic signed [gsv_pkg::IN_W-1:0]     goal_left_i,
  output logic                                valid_o,
  output gsv_pkg::core_t                      data_o
);
  import gsv_pkg::*;

  localparam int EXT_W = CW - (IN_W + 1) - GUARD_BITS;

  logic                   neg;
  logic signed [IN_W:0]   fwd_f;
  logic signed [IN_W:0]   left_f;
  logic signed [SQ_W-1:0] sq_fwd;
  logic signed [SQ_W-1:0] sq_left;
  cordic_t                cd_d, cd_q;
  logic [SQ_W-1:0]        sqf_q, sql_q;
  logic                   va_q;
  core_t                  out_d, out_q;
  logic                   vb_q;

  always_comb begin
    neg     = goal_forward_i[IN_W-1];
    fwd_f   = neg ? -{goal_forward_i[IN_W-1], goal_forward_i}
                  :  {goal_forward_i[IN_W-1], goal_forward_i};
    left_f  = neg ? -{goal_left_i[IN_W-1], goal_left_i}
                  :  {goal_left_i[IN_W-1], goal_left_i};
    sq_fwd  = goal_forward_i * goal_forward_i;
    sq_left = goal_left_i * goal_left_i;
    cd_d.x  = {{EXT_W{fwd_f[IN_W]}}, fwd_f, {GUARD_BITS{1'b0}}};
    cd_d.y  = {{EXT_W{left_f[IN_W]}}, left_f, {GUARD_BITS{1'b0}}};
    if (!neg) begin
      cd_d.z = '0;
    end else if (!goal_left_i[IN_W-1]) begin
      cd_d.z = PI_SCALED;
    end else begin
      cd_d.z = -PI_SCALED;
    end
  end

  always_comb begin
    out_d.cd      = cd_q;
    out_d.sq.rem  = sqf_q + sql_q;
    out_d.sq.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cd_q  <= cd_d;
      sqf_q <= SQ_W'(unsigned'(sq_fwd));
      sql_q <= SQ_W'(unsigned'(sq_left));
      out_q <= out_d;
    end
  end

  assign valid_o = vb_q;
  assign data_o  = out_q;

endmodule

// ----- src/gsv_core.sv -----
`timescale 1ns / 1ps
module gsv_core #(
  parameter int ATAN_ITERATIONS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  gsv_pkg::core_t data_i,
  output logic           valid_o,
  output gsv_pkg::core_t data_o
);
  import gsv_pkg::*;

  localparam int NSTG = (ATAN_ITERATIONS > SQRT_STEPS) ? ATAN_ITERATIONS : SQRT_STEPS;

  core_t            st_q [NSTG];
  logic [NSTG-1:0]  v_q;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    core_t src;
    logic  src_v;
    core_t nxt;

    if (k == 0) begin : g_head
      assign src   = data_i;
      assign src_v = valid_i;
    end else begin : g_body
      assign src   = st_q[k-1];
      assign src_v = v_q[k-1];
    end

    always_comb begin
      nxt = src;
      if (k < ATAN_ITERATIONS) begin
        nxt.cd = cordic_step(src.cd, k);
      end
      if (k < SQRT_STEPS) begin
        nxt.sq = sqrt_step(src.sq, k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign data_o  = st_q[NSTG-1];

endmodule

// ----- src/gsv_rule.sv -----
`timescale 1ns / 1ps
module gsv_rule (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  gsv_pkg::core_t                       data_i,
  input  gsv_pkg::cfg_t                        cfg_i,
  output logic                                 valid_o,
  output logic        [gsv_pkg::SPEED_W-1:0]   linear_speed_o,
  output logic signed [gsv_pkg::TURN_W-1:0]    turn_rate_o,
  output logic                                 arrived_o
);
  import gsv_pkg::*;

  // stage 1: round bearing and distance
  logic signed [CW-1:0]    z_rnd;
  logic signed [ANG_W-1:0] ang;
  logic [ANG_W-1:0]        mag_d, mag_q;
  logic                    neg_d, neg1_q;
  logic [DIST_W-1:0]       dist_d, dist_q;
  logic                    v1_q;

  always_comb begin
    z_rnd  = data_i.cd.z + ANG_ROUND;
    ang    = z_rnd[ROUND_SHIFT +: ANG_W];
    neg_d  = ang[ANG_W-1];
    mag_d  = neg_d ? ANG_W'(-ang) : ANG_W'(ang);
    dist_d = data_i.sq.root[DIST_W-1:0] + DIST_W'(data_i.sq.rem > data_i.sq.root);
  end

  // stage 2: compare against thresholds, scale distance by one tenth
  logic [PROD_W-1:0] prod_d, prod_q;
  logic gt_coarse_q, lt_slow_q, ge_fine_q, le_aligned_q, le_arrive_q, gt_far_q;
  logic neg2_q;
  logic v2_q;

  assign prod_d = (PROD_W'(dist_q) + PROD_W'(5)) * DIV10_MUL;

  // stage 3: select the command
  logic [QUOT_W-1:0]        quot;
  logic [SPEED_W-1:0]       speed_d, speed_q;
  logic [TURN_W-1:0]        rate;
  logic signed [TURN_W-1:0] turn_d, turn_q;
  logic                     arrived_d, arrived_q;
  logic                     v3_q;

  always_comb begin
    quot      = prod_q[PROD_W-1:DIV10_SHIFT];
    rate      = '0;
    speed_d   = '0;
    arrived_d = 1'b0;
    if (gt_coarse_q) begin
      rate = lt_slow_q ? RATE_SLOW : RATE_COARSE;
    end else begin
      if (ge_fine_q) begin
        rate = RATE_FINE;
      end
      if (le_arrive_q) begin
        rate      = '0;
        arrived_d = 1'b1;
      end else if (gt_far_q) begin
        speed_d = le_aligned_q ? cfg_i.fast_speed : cfg_i.cruise_speed;
      end else if (quot > QUOT_W'(SPEED_MAX)) begin
        speed_d = SPEED_MAX;
      end else begin
        speed_d = quot[SPEED_W-1:0];
      end
    end
    turn_d = neg2_q ? -signed'(rate) : signed'(rate);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q        <= mag_d;
      neg1_q       <= neg_d;
      dist_q       <= dist_d;
      prod_q       <= prod_d;
      gt_coarse_q  <= mag_q > ANG_W'(cfg_i.coarse_angle);
      lt_slow_q    <= mag_q < ANG_W'(cfg_i.slow_turn_angle);
      ge_fine_q    <= mag_q >= ANG_W'(cfg_i.fine_angle);
      le_aligned_q <= mag_q <= ANG_W'(cfg_i.aligned_angle);
      le_arrive_q  <= dist_q <= cfg_i.arrive_distance;
      gt_far_q     <= dist_q > cfg_i.far_distance;
      neg2_q       <= neg1_q;
      speed_q      <= speed_d;
      turn_q       <= turn_d;
      arrived_q    <= arrived_d;
    end
  end

  assign valid_o        = v3_q;
  assign linear_speed_o = speed_q;
  assign turn_rate_o    = turn_q;
  assign arrived_o      = arrived_q;

endmodule

// ----- src/goal_seek_velocity_rule.sv -----
`timescale 1ns / 1ps
// Pipeline: prep stages, then one core stage per CORDIC iteration (default 16) or sqrt
// step, whichever are more, then rule stages; sqrt takes one root bit per stage.
// Throughput: one item per cycle; a stalled output holds every stage in place.
// Reset: rst_ni clears all stage valid bits and loads the register defaults.
// No clearing pass; no stored table needs one.
module goal_seek_velocity_rule #(
  parameter int ATAN_ITERATIONS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [gsv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [gsv_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [gsv_pkg::IN_W-1:0]      goal_forward_i,
  input  logic signed [gsv_pkg::IN_W-1:0]      goal_left_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic        [gsv_pkg::SPEED_W-1:0]   linear_speed_o,
  output logic signed [gsv_pkg::TURN_W-1:0]    turn_rate_o,
  output logic                                 arrived_o
);
  import gsv_pkg::*;

  cfg_t  cfg_q;
  logic  en;
  logic  prep_v, core_v;
  core_t prep_data, core_data;

  // advance the whole pipeline unless a result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COARSE_ANGLE:    cfg_q.coarse_angle    <= cfg_wdata_i[ANGLE_CFG_W-1:0];
        CFG_SLOW_TURN_ANGLE: cfg_q.slow_turn_angle <= cfg_wdata_i[ANGLE_CFG_W-1:0];
        CFG_FINE_ANGLE:      cfg_q.fine_angle      <= cfg_wdata_i[ANGLE_CFG_W-1:0];
        CFG_ALIGNED_ANGLE:   cfg_q.aligned_angle   <= cfg_wdata_i[ANGLE_CFG_W-1:0];
        CFG_ARRIVE_DISTANCE: cfg_q.arrive_distance <= cfg_wdata_i[DIST_W-1:0];
        CFG_FAR_DISTANCE:    cfg_q.far_distance    <= cfg_wdata_i[DIST_W-1:0];
        CFG_FAST_SPEED:      cfg_q.fast_speed      <= cfg_wdata_i[SPEED_W-1:0];
        CFG_CRUISE_SPEED:    cfg_q.cruise_speed    <= cfg_wdata_i[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  gsv_prep u_prep (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .goal_forward_i (goal_forward_i),
    .goal_left_i    (goal_left_i),
    .valid_o        (prep_v),
    .data_o         (prep_data)
  );

  gsv_core #(
    .ATAN_ITERATIONS (ATAN_ITERATIONS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_v),
    .data_i  (prep_data),
    .valid_o (core_v),
    .data_o  (core_data)
  );

  gsv_rule u_rule (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (core_v),
    .data_i         (core_data),
    .cfg_i          (cfg_q),
    .valid_o        (out_valid_o),
    .linear_speed_o (linear_speed_o),
    .turn_rate_o    (turn_rate_o),
    .arrived_o      (arrived_o)
  );

endmodule

// ----- src/gsv_checker.sv -----
`timescale 1ns / 1ps
module gsv_props (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic        [gsv_pkg::SPEED_W-1:0] linear_speed_o,
  input logic signed [gsv_pkg::TURN_W-1:0]  turn_rate_o,
  input logic                               arrived_o
);
  import gsv_pkg::*;

  localparam logic signed [TURN_W-1:0] RC = signed'(RATE_COARSE);
  localparam logic signed [TURN_W-1:0] RS = signed'(RATE_SLOW);
  localparam logic signed [TURN_W-1:0] RF = signed'(RATE_FINE);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(linear_speed_o)
      && $stable(turn_rate_o) && $stable(arrived_o))
    else $error("result changed while stalled");

  a_arrive_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arrived_o |-> linear_speed_o == '0 && turn_rate_o == '0)
    else $error("arrival with nonzero motion");

  a_rate_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> turn_rate_o == '0 || turn_rate_o == RC || turn_rate_o == -RC
      || turn_rate_o == RS || turn_rate_o == -RS || turn_rate_o == RF
      || turn_rate_o == -RF)
    else $error("turn rate outside the fixed set");

  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

endmodule

bind goal_seek_velocity_rule gsv_props u_gsv_props (.*);

// ----- tb/gsv_checker.sv -----
`timescale 1ns / 1ps
module gsv_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gsv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gsv_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [gsv_pkg::IN_W-1:0]   goal_forward_i,
  input  logic signed [gsv_pkg::IN_W-1:0]   goal_left_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [gsv_pkg::SPEED_W-1:0]       linear_speed_i,
  input  logic signed [gsv_pkg::TURN_W-1:0] turn_rate_i,
  input  logic                              arrived_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import gsv_pkg::*;

  localparam int     CORDIC_STEPS = 16;
  localparam longint PI_Q30       = 64'sd3373259426;
  localparam longint TURN_ONE     = 4096;
  localparam longint TURN_FAST    = (TURN_ONE * 2 + 5) / 10;
  localparam longint TURN_SLOW    = (TURN_ONE + 5) / 10;
  localparam longint TURN_FINE    = (TURN_ONE * 2 + 50) / 100;
  localparam longint SPEED_CAP    = 4095;

  localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768
  };

  localparam cfg_t LIMITS_AT_RESET = '{
    coarse_angle:    14'd819,
    slow_turn_angle: 14'd1229,
    fine_angle:      14'd123,
    aligned_angle:   14'd205,
    arrive_distance: 16'd205,
    far_distance:    16'd8192,
    fast_speed:      12'd1638,
    cruise_speed:    12'd1229
  };

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [TURN_W-1:0]  turn;
    logic               arrived;
  } motion_t;

  cfg_t        limits;
  motion_t     motion_q[$];
  int unsigned fails;

  function automatic longint unsigned root_rounded(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    longint unsigned rem;
    r   = 0;
    rem = s;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic longint bearing_q12(longint fwd, longint left);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    int     i;
    x = fwd;
    y = left;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q30[i];
      end else if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q30[i];
      end
    end
    return (z + (longint'(1) <<< 17)) >>> 18;
  endfunction

  function automatic motion_t predict_motion(logic signed [IN_W-1:0] fwd,
                                             logic signed [IN_W-1:0] left);
    longint          x;
    longint          y;
    longint          ang;
    longint          mag;
    longint          rate;
    longint unsigned goal_dist;
    longint unsigned speed;
    motion_t         m;
    x         = fwd;
    y         = left;
    goal_dist = root_rounded(longint'(x * x + y * y));
    ang       = bearing_q12(x, y);
    mag       = (ang < 0) ? -ang : ang;
    rate      = 0;
    speed     = 0;
    m.arrived = 1'b0;
    if (mag > longint'(limits.coarse_angle)) begin
      rate = (mag < longint'(limits.slow_turn_angle)) ? TURN_SLOW : TURN_FAST;
    end else begin
      if (mag >= longint'(limits.fine_angle)) rate = TURN_FINE;
      if (goal_dist <= limits.arrive_distance) begin
        rate      = 0;
        m.arrived = 1'b1;
      end else if (goal_dist > limits.far_distance) begin
        speed = (mag <= longint'(limits.aligned_angle)) ? limits.fast_speed
                                                         : limits.cruise_speed;
      end else begin
        speed = (goal_dist + 5) / 10;
        if (speed > SPEED_CAP) speed = SPEED_CAP;
      end
    end
    if (ang < 0) rate = -rate;
    m.speed = SPEED_W'(speed);
    m.turn  = TURN_W'(rate);
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    motion_t want;
    if (!rst_ni) begin
      limits = LIMITS_AT_RESET;
      motion_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_COARSE_ANGLE:    limits.coarse_angle    = cfg_wdata_i[ANGLE_CFG_W-1:0];
          CFG_SLOW_TURN_ANGLE: limits.slow_turn_angle = cfg_wdata_i[ANGLE_CFG_W-1:0];
          CFG_FINE_ANGLE:      limits.fine_angle      = cfg_wdata_i[ANGLE_CFG_W-1:0];
          CFG_ALIGNED_ANGLE:   limits.aligned_angle   = cfg_wdata_i[ANGLE_CFG_W-1:0];
          CFG_ARRIVE_DISTANCE: limits.arrive_distance = cfg_wdata_i[DIST_W-1:0];
          CFG_FAR_DISTANCE:    limits.far_distance    = cfg_wdata_i[DIST_W-1:0];
          CFG_FAST_SPEED:      limits.fast_speed      = cfg_wdata_i[SPEED_W-1:0];
          CFG_CRUISE_SPEED:    limits.cruise_speed    = cfg_wdata_i[SPEED_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (motion_q.size() == 0) begin
          $error("command transfer with nothing outstanding: speed %0d turn %0d arrived %0d",
                 linear_speed_i, turn_rate_i, arrived_i);
          fails++;
        end else begin
          want = motion_q.pop_front();
          if (want.speed !== linear_speed_i) begin
            $error("linear_speed: expected %0d, actual %0d", want.speed, linear_speed_i);
            fails++;
          end
          if (want.turn !== turn_rate_i) begin
            $error("turn_rate: expected %0d, actual %0d", $signed(want.turn), turn_rate_i);
            fails++;
          end
          if (want.arrived !== arrived_i) begin
            $error("arrived: expected %0d, actual %0d", want.arrived, arrived_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        motion_q.push_back(predict_motion(goal_forward_i, goal_left_i));
      end
      fail_count_o <= fails;
      pending_o    <= motion_q.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import gsv_pkg::*;

  localparam int PIPE_LATENCY = 21;
  localparam int HOLD_CYCLES  = 150;
  localparam int RUN_LIMIT_NS = 1000000;
  localparam int ANGLE_TOP    = 12868;
  localparam int DIST_TOP     = 46341;
  localparam int SPEED_TOP    = 4095;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'd11;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx     = CFG_COARSE_ANGLE;
  logic [CFG_DATA_W-1:0]    cfg_wdata   = '0;
  logic                     goal_valid  = 1'b0;
  logic                     goal_ready;
  logic signed [IN_W-1:0]   goal_fwd    = '0;
  logic signed [IN_W-1:0]   goal_left   = '0;
  logic                     cmd_valid;
  logic                     cmd_ready   = 1'b0;
  logic [SPEED_W-1:0]       cmd_speed;
  logic signed [TURN_W-1:0] cmd_turn;
  logic                     cmd_arrived;

  int unsigned fail_count;
  int unsigned pending;
  bit          tx_gapless;
  bit          rx_hold_req;
  bit          rx_holding;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  goal_seek_velocity_rule DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (goal_valid),
    .in_ready_o     (goal_ready),
    .goal_forward_i (goal_fwd),
    .goal_left_i    (goal_left),
    .out_valid_o    (cmd_valid),
    .out_ready_i    (cmd_ready),
    .linear_speed_o (cmd_speed),
    .turn_rate_o    (cmd_turn),
    .arrived_o      (cmd_arrived)
  );

  gsv_checker motion_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (goal_valid),
    .in_ready_i     (goal_ready),
    .goal_forward_i (goal_fwd),
    .goal_left_i    (goal_left),
    .out_valid_i    (cmd_valid),
    .out_ready_i    (cmd_ready),
    .linear_speed_i (cmd_speed),
    .turn_rate_i    (cmd_turn),
    .arrived_i      (cmd_arrived),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  function automatic int unsigned goal_gap();
    int unsigned r;
    if (tx_gapless) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic cfg_t random_limits();
    cfg_t lim;
    lim.coarse_angle    = ANGLE_CFG_W'($urandom_range(0, 3000));
    lim.slow_turn_angle = ANGLE_CFG_W'($urandom_range(0, 4000));
    lim.fine_angle      = ANGLE_CFG_W'($urandom_range(0, 1000));
    lim.aligned_angle   = ANGLE_CFG_W'($urandom_range(0, 1500));
    lim.arrive_distance = DIST_W'($urandom_range(0, 2000));
    lim.far_distance    = DIST_W'($urandom_range(0, 20000));
    lim.fast_speed      = SPEED_W'($urandom_range(0, SPEED_TOP));
    lim.cruise_speed    = SPEED_W'($urandom_range(0, SPEED_TOP));
    return lim;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // upper bits beyond each register's width carry junk
  task automatic program_limits(input cfg_t lim);
    write_reg(CFG_COARSE_ANGLE,    {2'($urandom), lim.coarse_angle});
    write_reg(CFG_SLOW_TURN_ANGLE, {2'($urandom), lim.slow_turn_angle});
    write_reg(CFG_FINE_ANGLE,      {2'($urandom), lim.fine_angle});
    write_reg(CFG_ALIGNED_ANGLE,   {2'($urandom), lim.aligned_angle});
    write_reg(CFG_ARRIVE_DISTANCE, lim.arrive_distance);
    write_reg(CFG_FAR_DISTANCE,    lim.far_distance);
    write_reg(CFG_FAST_SPEED,      {4'($urandom), lim.fast_speed});
    write_reg(CFG_CRUISE_SPEED,    {4'($urandom), lim.cruise_speed});
    write_reg(CFG_UNMAPPED,        16'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic send_goal(input int fwd, input int left);
    int unsigned gap;
    gap = goal_gap();
    if (gap != 0) begin
      goal_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    goal_valid <= 1'b1;
    goal_fwd   <= 16'(fwd);
    goal_left  <= 16'(left);
    @(posedge clk);
    while (!goal_ready) @(posedge clk);
  endtask

  task automatic send_random_goal();
    int fwd;
    int left;
    int span;
    case ($urandom_range(0, 4))
      0: begin
        fwd  = int'($urandom_range(0, 65535)) - 32768;
        left = int'($urandom_range(0, 65535)) - 32768;
      end
      1: begin
        fwd  = int'($urandom_range(0, 700)) - 350;
        left = int'($urandom_range(0, 700)) - 350;
      end
      default: begin
        span = (1 << $urandom_range(4, 15)) - 1;
        fwd  = $urandom_range(0, span);
        left = $urandom_range(0, fwd >> $urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1) left = -left;
        if ($urandom_range(0, 9) == 0) fwd = -fwd - 1;
      end
    endcase
    send_goal(fwd, left);
  endtask

  task automatic send_random(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) tx_gapless = ($urandom_range(0, 4) == 0);
      send_random_goal();
    end
    tx_gapless = 1'b0;
  endtask

  task automatic send_corners();
    send_goal(-32768, -32768);
    send_goal(32767, 32767);
    send_goal(-32768, 32767);
    send_goal(32767, -32768);
    send_goal(0, 0);
    send_goal(32767, 0);
    send_goal(-32768, 0);
    send_goal(0, -32768);
  endtask

  // drop valid, drain outstanding commands, then let the pipe go quiet
  task automatic settle();
    goal_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  initial begin : receiver
    int unsigned pick;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_holding  = 1'b1;
        cmd_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_holding = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          cmd_ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (pick < 88) begin
          cmd_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (pick < 96) begin
          cmd_ready <= 1'b1;
          repeat ($urandom_range(30, 80)) @(posedge clk);
        end else begin
          cmd_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    cfg_t lim;
    int   n;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_corners();
    send_goal(-4096, 0);
    send_goal(-4096, -1);
    send_goal(-1, 0);
    send_goal(100, 0);
    send_goal(205, 0);
    send_goal(206, 0);
    send_goal(150, 20);
    send_goal(10, 100);
    send_goal(4096, 0);
    send_goal(4096, 300);
    send_goal(4096, 1000);
    send_goal(4096, -3000);
    send_goal(0, 4096);
    send_goal(8192, 0);
    send_goal(8193, 0);
    send_goal(20000, 500);
    send_goal(20000, 2000);
    send_random(120);
    settle();

    program_limits(random_limits());
    send_corners();
    send_random(90);
    settle();

    program_limits('0);
    send_corners();
    send_random(40);
    settle();

    lim.coarse_angle    = ANGLE_CFG_W'(ANGLE_TOP);
    lim.slow_turn_angle = ANGLE_CFG_W'(ANGLE_TOP);
    lim.fine_angle      = ANGLE_CFG_W'(ANGLE_TOP);
    lim.aligned_angle   = ANGLE_CFG_W'(ANGLE_TOP);
    lim.arrive_distance = DIST_W'(DIST_TOP);
    lim.far_distance    = DIST_W'(DIST_TOP);
    lim.fast_speed      = SPEED_W'(SPEED_TOP);
    lim.cruise_speed    = SPEED_W'(SPEED_TOP);
    program_limits(lim);
    send_corners();
    send_random(25);
    settle();

    // far limit out of reach so near speeds saturate
    lim.arrive_distance = '0;
    lim.fine_angle      = '0;
    program_limits(lim);
    send_corners();
    send_random(50);
    settle();

    lim.coarse_angle    = ANGLE_CFG_W'(2000);
    lim.slow_turn_angle = ANGLE_CFG_W'(600);
    lim.fine_angle      = ANGLE_CFG_W'(3000);
    lim.aligned_angle   = ANGLE_CFG_W'(50);
    lim.arrive_distance = DIST_W'(9000);
    lim.far_distance    = DIST_W'(300);
    lim.fast_speed      = SPEED_W'(SPEED_TOP);
    lim.cruise_speed    = SPEED_W'(1);
    program_limits(lim);
    send_corners();
    send_random(50);
    settle();

    program_limits(random_limits());
    rx_hold_req = 1'b1;
    while (!rx_holding) @(posedge clk);
    rx_hold_req = 1'b0;
    tx_gapless = 1'b1;
    for (n = 0; n < 50; n++) send_random_goal();
    tx_gapless = 1'b0;
    send_random(40);
    settle();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/gsv_pkg.sv
src/gsv_prep.sv
src/gsv_core.sv
src/gsv_rule.sv
src/goal_seek_velocity_rule.sv
src/gsv_checker.sv
tb/gsv_checker.sv
tb/tb_top.sv
